### hdl/e2dv_pkg.sv
`timescale 1ns / 1ps

package e2dv_pkg;

  // Input item: three binary angles
  typedef struct packed {
    logic [15:0] pitch_angle;
    logic [15:0] yaw_angle;
    logic [15:0] roll_angle;
  } in_item_t;

  // Result item: forward, right and up vectors
  typedef struct packed {
    logic signed [15:0] forward_x;
    logic signed [15:0] forward_y;
    logic signed [15:0] forward_z;
    logic signed [15:0] right_x;
    logic signed [15:0] right_y;
    logic signed [15:0] right_z;
    logic signed [15:0] up_x;
    logic signed [15:0] up_y;
    logic signed [15:0] up_z;
  } out_item_t;

  // Sine/cosine pipeline depth: angle prep (3), six Horner steps (3 each), finish (2)
  localparam int HORNER_STEPS = 6;
  localparam int SC_LAT       = 3 + 3 * HORNER_STEPS + 2;

  localparam logic [32:0] Q32_ONE  = 33'h1_0000_0000;
  localparam logic [63:0] HALF_PI  = 64'd6746518852;

  // Horner divisors per lane (lane 0 sine, lane 1 cosine; the last cosine step halves)
  localparam logic [7:0] STEP_DIV [2][HORNER_STEPS] = '{
    '{8'd156, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6},
    '{8'd132, 8'd90,  8'd56, 8'd30, 8'd12, 8'd2}
  };

  // floor(2^32 / divisor), the quotient estimate is at most one low
  localparam logic [31:0] STEP_RCP [2][HORNER_STEPS] = '{
    '{32'd27531841, 32'd39045157, 32'd59652323,
      32'd102261126, 32'd214748364, 32'd715827882},
    '{32'd32537631, 32'd47721858, 32'd76695844,
      32'd143165576, 32'd357913941, 32'd2147483648}
  };

  // Q1.30 product rounding, half away from zero
  function automatic logic signed [31:0] qround(input logic signed [63:0] p);
    logic signed [63:0] t;
    t = p + 64'sd536870912 - {63'd0, p[63]};
    return t[61:30];
  endfunction

endpackage

### hdl/e2dv_sincos.sv
`timescale 1ns / 1ps

module e2dv_sincos import e2dv_pkg::*; #(
  parameter int ANGLE_BITS = 16
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [15:0]        angle_i,
  output logic signed [31:0] sin_o,
  output logic signed [31:0] cos_o
);

  typedef enum logic [1:0] {QUAD_0, QUAD_90, QUAD_180, QUAD_270} quad_e;

  typedef struct packed {
    quad_e       quad;
    logic        swap;
    logic [31:0] r;
    logic [31:0] r2;
  } ctx_t;

  localparam logic [31:0] AMASK = 32'((64'd1 << ANGLE_BITS) - 64'd1);
  localparam int          SHL   = 32 - ANGLE_BITS;

  // Fold the angle into the first octant
  logic [31:0] turn;
  logic [29:0] frac, oct;
  logic        swap;

  always_comb begin
    turn = 32'((32'(angle_i) & AMASK) << SHL);
    frac = turn[29:0];
    swap = frac > 30'h2000_0000;
    oct  = swap ? 30'(31'h4000_0000 - 31'(frac)) : frac;
  end

  // Scale to radians, then square
  quad_e       quad1_q, quad2_q;
  logic        swap1_q, swap2_q;
  logic [63:0] rad_prod_q;
  logic [31:0] rad_q;
  ctx_t        ctx3_q;
  logic [63:0] rad_sum;

  assign rad_sum = rad_prod_q + 64'h2000_0000;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      quad1_q       <= quad_e'(turn[31:30]);
      swap1_q       <= swap;
      rad_prod_q    <= 64'(oct) * HALF_PI;
      quad2_q       <= quad1_q;
      swap2_q       <= swap1_q;
      rad_q         <= rad_sum[61:30];
      ctx3_q.quad   <= quad2_q;
      ctx3_q.swap   <= swap2_q;
      ctx3_q.r      <= rad_q;
      ctx3_q.r2     <= 32'((64'(rad_q) * 64'(rad_q)) >> 32);
    end
  end

  // Horner chains, sine and cosine side by side
  ctx_t        ctx_w [HORNER_STEPS+1];
  logic [32:0] u_w   [2][HORNER_STEPS+1];

  assign ctx_w[0]  = ctx3_q;
  assign u_w[0][0] = Q32_ONE;
  assign u_w[1][0] = Q32_ONE;

  for (genvar i = 0; i < HORNER_STEPS; i++) begin : g_step
    ctx_t ctxa_q, ctxb_q, ctxc_q;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        ctxa_q <= ctx_w[i];
        ctxb_q <= ctxa_q;
        ctxc_q <= ctxb_q;
      end
    end

    assign ctx_w[i+1] = ctxc_q;

    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [63:0] p_q;
      logic [31:0] x_q;
      logic [63:0] e_q;
      logic [32:0] u_q;
      logic [31:0] q0;
      logic [39:0] rem;
      logic [32:0] quo;

      // Correct the reciprocal estimate by one
      always_comb begin
        q0  = e_q[63:32];
        rem = 40'(x_q) - 40'(q0) * 40'(STEP_DIV[l][i]);
        quo = (rem >= 40'(STEP_DIV[l][i])) ? 33'(q0) + 33'd1 : 33'(q0);
      end

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          p_q <= 64'(ctx_w[i].r2) * 64'(u_w[l][i]);
          x_q <= p_q[63:32];
          e_q <= 64'(p_q[63:32]) * 64'(STEP_RCP[l][i]);
          u_q <= Q32_ONE - quo;
        end
      end

      assign u_w[l][i+1] = u_q;
    end
  end

  // Finish sine, round both, place by quadrant
  logic [63:0] sp_q;
  logic [32:0] cf_q;
  quad_e       quadf_q;
  logic        swapf_q;
  logic [33:0] s_rnd, c_rnd;
  logic signed [31:0] a_val, b_val, s_d, c_d;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sp_q    <= 64'(ctx_w[HORNER_STEPS].r) * 64'(u_w[0][HORNER_STEPS]);
      cf_q    <= u_w[1][HORNER_STEPS];
      quadf_q <= ctx_w[HORNER_STEPS].quad;
      swapf_q <= ctx_w[HORNER_STEPS].swap;
    end
  end

  always_comb begin
    s_rnd = (34'(sp_q[63:32]) + 34'd2) >> 2;
    c_rnd = (34'(cf_q) + 34'd2) >> 2;
    a_val = swapf_q ? signed'({1'b0, c_rnd[30:0]}) : signed'({1'b0, s_rnd[30:0]});
    b_val = swapf_q ? signed'({1'b0, s_rnd[30:0]}) : signed'({1'b0, c_rnd[30:0]});
    case (quadf_q)
      QUAD_0:   begin s_d = a_val;  c_d = b_val;  end
      QUAD_90:  begin s_d = b_val;  c_d = -a_val; end
      QUAD_180: begin s_d = -a_val; c_d = -b_val; end
      default:  begin s_d = -b_val; c_d = a_val;  end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sin_o <= s_d;
      cos_o <= c_d;
    end
  end

endmodule

### hdl/euler_angles_to_direction_vectors_unit.sv
`timescale 1ns / 1ps
// Euler angles to forward/right/up direction vectors.
// Input channel: in_valid_i / in_stall_o with in_item_i carrying pitch, yaw and
// roll as binary angles (2^ANGLE_BITS per turn, upper bits ignored).
// Output channel: out_valid_o / out_stall_i with out_item_o holding the nine
// vector components, signed with FRAC_BITS fraction bits, saturated to 16 bits.
// The pipeline has 29 register stages: 23 stages in the sine/cosine pipeline
// (three angle stages, six three-stage Horner steps, two finish stages) and six
// product/rounding/sum stages. Throughput is one item per cycle while the receiver
// does not stall the pipeline; the multiplier in each Horner stage sets the
// stage depth.
// Reset clears all valid bits; the pipeline comes up empty.
// When the receiver stalls with a result waiting, the whole pipeline holds and
// in_stall_o rises in the same cycle; nothing is dropped or repeated.
module euler_angles_to_direction_vectors_unit import e2dv_pkg::*; #(
  parameter int ANGLE_BITS = 16,
  parameter int FRAC_BITS  = 14
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  localparam int LAT  = SC_LAT + 6;
  localparam int SH   = 30 - FRAC_BITS;
  localparam int SHM  = (SH > 0) ? SH - 1 : 0;
  localparam logic signed [35:0] HALF = (SH > 0) ? (36'sd1 <<< SHM) : 36'sd0;
  localparam logic signed [35:0] NEGB = (SH > 0) ? 36'sd1 : 36'sd0;

  logic           adv;
  logic [LAT-1:0] vld_q;

  assign adv         = !(vld_q[LAT-1] && out_stall_i);
  assign in_stall_o  = !adv;
  assign out_valid_o = vld_q[LAT-1];

  // Advance valid bits with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[LAT-2:0], in_valid_i};
    end
  end

  logic signed [31:0] ps, pc, ys, yc, rs, rc;

  e2dv_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_pitch (
    .clk_i(clk_i), .en_i(adv), .angle_i(in_item_i.pitch_angle), .sin_o(ps), .cos_o(pc)
  );
  e2dv_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_yaw (
    .clk_i(clk_i), .en_i(adv), .angle_i(in_item_i.yaw_angle), .sin_o(ys), .cos_o(yc)
  );
  e2dv_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_roll (
    .clk_i(clk_i), .en_i(adv), .angle_i(in_item_i.roll_angle), .sin_o(rs), .cos_o(rc)
  );

  // Product slots: 0 fwd x, 1 fwd z, 2 right x, 3 right y, 4 up y,
  // 5 up x left pair, 6 up z left pair, 7 up x right term, 8 up z right term
  logic signed [31:0] nps, nys, nyc;
  logic signed [63:0] pm1_q [9];
  logic signed [31:0] rd2_q [9];
  logic signed [31:0] rd3_q [9];
  logic signed [31:0] rd4_q [9];
  logic signed [63:0] pm3_q [2];
  logic signed [31:0] fy1_q, fy2_q, fy3_q, fy4_q;
  logic signed [31:0] rz1_q, rz2_q, rz3_q, rz4_q;
  logic signed [31:0] rc1_q, rc2_q;
  logic signed [35:0] v5_q [9];

  assign nps = -ps;
  assign nys = -ys;
  assign nyc = -yc;

  // First products, rounding, second products, rounding, sums
  always_ff @(posedge clk_i) begin
    if (adv) begin
      pm1_q[0] <= 64'(pc) * 64'(nys);
      pm1_q[1] <= 64'(pc) * 64'(nyc);
      pm1_q[2] <= 64'(rc) * 64'(yc);
      pm1_q[3] <= 64'(rs) * 64'(yc);
      pm1_q[4] <= 64'(pc) * 64'(rc);
      pm1_q[5] <= 64'(ps) * 64'(ys);
      pm1_q[6] <= 64'(nps) * 64'(nyc);
      pm1_q[7] <= 64'(nyc) * 64'(rs);
      pm1_q[8] <= 64'(ys) * 64'(rs);
      fy1_q    <= ps;
      rz1_q    <= nys;
      rc1_q    <= rc;

      for (int k = 0; k < 9; k++) begin
        rd2_q[k] <= qround(pm1_q[k]);
      end
      fy2_q <= fy1_q;
      rz2_q <= rz1_q;
      rc2_q <= rc1_q;

      rd3_q    <= rd2_q;
      pm3_q[0] <= 64'(rd2_q[5]) * 64'(rc2_q);
      pm3_q[1] <= 64'(rd2_q[6]) * 64'(rc2_q);
      fy3_q    <= fy2_q;
      rz3_q    <= rz2_q;

      for (int k = 0; k < 9; k++) begin
        if (k != 5 && k != 6) begin
          rd4_q[k] <= rd3_q[k];
        end
      end
      rd4_q[5] <= qround(pm3_q[0]);
      rd4_q[6] <= qround(pm3_q[1]);
      fy4_q    <= fy3_q;
      rz4_q    <= rz3_q;

      v5_q[0] <= 36'(rd4_q[0]);
      v5_q[1] <= 36'(fy4_q);
      v5_q[2] <= 36'(rd4_q[1]);
      v5_q[3] <= 36'(rd4_q[2]);
      v5_q[4] <= 36'(rd4_q[3]);
      v5_q[5] <= 36'(rz4_q);
      v5_q[6] <= 36'(rd4_q[5]) + 36'(rd4_q[7]);
      v5_q[7] <= 36'(rd4_q[4]);
      v5_q[8] <= 36'(rd4_q[6]) + 36'(rd4_q[8]);
    end
  end

  // Round to output precision and saturate
  logic signed [15:0] fld [9];

  always_comb begin
    logic signed [35:0] t;
    for (int k = 0; k < 9; k++) begin
      t = (v5_q[k] + HALF - (v5_q[k][35] ? NEGB : 36'sd0)) >>> SH;
      if (t > 36'sd32767) begin
        fld[k] = 16'sh7fff;
      end else if (t < -36'sd32768) begin
        fld[k] = 16'sh8000;
      end else begin
        fld[k] = t[15:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_item_o.forward_x <= fld[0];
      out_item_o.forward_y <= fld[1];
      out_item_o.forward_z <= fld[2];
      out_item_o.right_x   <= fld[3];
      out_item_o.right_y   <= fld[4];
      out_item_o.right_z   <= fld[5];
      out_item_o.up_x      <= fld[6];
      out_item_o.up_y      <= fld[7];
      out_item_o.up_z      <= fld[8];
    end
  end

endmodule
